FILE: design/assert_macros.svh
// ----------------------------------------------------------------------------
// Assertion macros
// Shared concurrent assertion forms for the matrix unit.
// ----------------------------------------------------------------------------
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Same-cycle implication, disabled while reset is high
`define ASSERT_NOW(label, clk, rst, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error(msg);

// Next-cycle implication, disabled while reset is high
`define ASSERT_NEXT(label, clk, rst, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error(msg);

`endif

FILE: design/smma_pkg.sv
// ----------------------------------------------------------------------------
// smma_pkg
// Types, constants and helpers shared by the small matrix multiply/add unit.
// ----------------------------------------------------------------------------
`default_nettype none

package smma_pkg;

  // Sizes
  localparam int unsigned MAX_DIM_DEFAULT = 8;
  localparam int unsigned VALUE_WIDTH     = 32;
  localparam int unsigned FRAC_BITS       = 16;
  localparam int unsigned TERM_WIDTH      = 2 * VALUE_WIDTH - FRAC_BITS;
  localparam int unsigned ACC_WIDTH       = TERM_WIDTH + 3;
  localparam int unsigned DIM_WIDTH       = 4;
  localparam int unsigned MODE_WIDTH      = 2;
  localparam int unsigned INDEX_WIDTH     = 3;
  localparam int unsigned PADDR_WIDTH     = 4;
  localparam int unsigned PDATA_WIDTH     = 32;

  // Register indexes (paddr word offset)
  localparam logic [1:0] REG_ROW_COUNT   = 2'd0;
  localparam logic [1:0] REG_INNER_COUNT = 2'd1;
  localparam logic [1:0] REG_COL_COUNT   = 2'd2;
  localparam logic [1:0] REG_OP_MODE     = 2'd3;

  // Operation modes
  localparam logic [MODE_WIDTH-1:0] MODE_MULTIPLY     = 2'd0;
  localparam logic [MODE_WIDTH-1:0] MODE_ADD          = 2'd1;
  localparam logic [MODE_WIDTH-1:0] MODE_SUBTRACT     = 2'd2;
  localparam logic [MODE_WIDTH-1:0] MODE_MULTIPLY_ALT = 2'd3;

  // Register reset values
  localparam logic [DIM_WIDTH-1:0]  ROW_COUNT_RESET   = 4'd8;
  localparam logic [DIM_WIDTH-1:0]  INNER_COUNT_RESET = 4'd8;
  localparam logic [DIM_WIDTH-1:0]  COL_COUNT_RESET   = 4'd8;
  localparam logic [MODE_WIDTH-1:0] OP_MODE_RESET     = MODE_MULTIPLY;

  // Input word
  typedef struct packed {
    logic                          operand_select;
    logic signed [VALUE_WIDTH-1:0] element_value;
  } load_word_t;

  // Output word
  typedef struct packed {
    logic signed [VALUE_WIDTH-1:0] result_value;
    logic [INDEX_WIDTH-1:0]        result_row;
    logic [INDEX_WIDTH-1:0]        result_col;
    logic                          saturated;
    logic                          last_result;
  } result_word_t;

  // Kind of term formed by the shared unit
  typedef enum logic [1:0] {
    TERM_PRODUCT,
    TERM_SUM,
    TERM_DIFF
  } term_kind_t;

  // Sequencer to arithmetic unit controls
  typedef struct packed {
    logic       capture;
    logic       accumulate;
    logic       first;
    term_kind_t kind;
  } alu_ctrl_t;

  // Sequencer states
  typedef enum logic [2:0] {
    ST_IDLE,
    ST_READ,
    ST_MULT,
    ST_ACCUM,
    ST_EMIT
  } seq_state_t;

  // Zero acts as one, anything above the limit acts as the limit
  function automatic logic [DIM_WIDTH-1:0] dim_clamp(input logic [DIM_WIDTH-1:0] v,
                                                     input logic [DIM_WIDTH-1:0] limit);
    logic [DIM_WIDTH-1:0] d;
    d = v;
    if (v == '0) begin
      d = DIM_WIDTH'(1);
    end else if (v > limit) begin
      d = limit;
    end
    return d;
  endfunction

endpackage

`default_nettype wire

FILE: design/smma_ram.sv
// ----------------------------------------------------------------------------
// smma_ram
// Simple dual-port RAM: one write port, one read port with registered data.
// ----------------------------------------------------------------------------
`default_nettype none

module smma_ram import smma_pkg::*; #(
  parameter int unsigned WIDTH = VALUE_WIDTH,
  parameter int unsigned DEPTH = MAX_DIM_DEFAULT * MAX_DIM_DEFAULT
) (
  input  logic                                    clk,
  input  logic                                    wr_en,
  input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] wr_addr,
  input  logic [WIDTH-1:0]                        wr_data,
  input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] rd_addr,
  output logic [WIDTH-1:0]                        rd_data
);

  logic [WIDTH-1:0] mem [DEPTH];

  // Write, and register the read data
  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
    rd_data <= mem[rd_addr];
  end

endmodule

`default_nettype wire

FILE: design/smma_alu.sv
// ----------------------------------------------------------------------------
// smma_alu
// Shared multiply / add / subtract unit with accumulator and saturation.
// ----------------------------------------------------------------------------
`default_nettype none

module smma_alu import smma_pkg::*; (
  input  logic                          clk,
  input  alu_ctrl_t                     ctrl,
  input  logic signed [VALUE_WIDTH-1:0] a,
  input  logic signed [VALUE_WIDTH-1:0] b,
  output logic signed [VALUE_WIDTH-1:0] sat_value,
  output logic                          clipped
);

  logic signed [2*VALUE_WIDTH-1:0]    product;
  logic signed [ACC_WIDTH-1:0]        term_next;
  logic signed [ACC_WIDTH-1:0]        term;
  logic signed [ACC_WIDTH-1:0]        acc;
  logic [ACC_WIDTH-VALUE_WIDTH:0]     upper;
  logic                               in_range;

  // Form one term: floored Q16.16 product, or element sum or difference
  always_comb begin
    product = a * b;
    unique case (ctrl.kind)
      TERM_PRODUCT: term_next = ACC_WIDTH'(product >>> FRAC_BITS);
      TERM_SUM:     term_next = ACC_WIDTH'(a) + ACC_WIDTH'(b);
      TERM_DIFF:    term_next = ACC_WIDTH'(a) - ACC_WIDTH'(b);
      default:      term_next = '0;
    endcase
  end

  // Hold the term, then add it in; the first term of an element restarts the sum
  always_ff @(posedge clk) begin
    if (ctrl.capture) begin
      term <= term_next;
    end
    if (ctrl.accumulate) begin
      acc <= (ctrl.first ? ACC_WIDTH'(0) : acc) + term;
    end
  end

  // Clip the sum to the value range
  always_comb begin
    upper    = acc[ACC_WIDTH-1:VALUE_WIDTH-1];
    in_range = (&upper) | ~(|upper);
    clipped  = ~in_range;
    if (in_range) begin
      sat_value = acc[VALUE_WIDTH-1:0];
    end else if (acc[ACC_WIDTH-1]) begin
      sat_value = {1'b1, {(VALUE_WIDTH-1){1'b0}}};
    end else begin
      sat_value = {1'b0, {(VALUE_WIDTH-1){1'b1}}};
    end
  end

endmodule

`default_nettype wire

FILE: design/small_matrix_multiply_add.sv
// ----------------------------------------------------------------------------
// small_matrix_multiply_add
// Loads matrices A and B element by element and streams out A*B, A+B or A-B
// in column-major order with Q16.16 saturation.
// ----------------------------------------------------------------------------
//
//   channel   direction  handshake                     word
//   load      in         load_valid / load_stall       load_word_t
//   result    out        result_valid / result_stall   result_word_t
//   config    in         APB psel/penable/pwrite       4 registers, 32-bit
//
// A load word is taken whenever load_stall is low; load_stall is high while a
// result is being produced. Multiply: each result element steps through read,
// multiply and accumulate for each of K terms, then emit, through the one shared
// multiply-accumulate unit and the single read port of each store.
// Add/subtract: read, form, accumulate, emit. A stalled result word holds the
// sequencer in its emit step. Reset is synchronous; the stores need no clearing.
//
`default_nettype none
`include "assert_macros.svh"

module small_matrix_multiply_add import smma_pkg::*; #(
  parameter int unsigned MAX_DIM = MAX_DIM_DEFAULT
) (
  input  logic                   clk,
  input  logic                   rst,
  input  logic                   load_valid,
  output logic                   load_stall,
  input  load_word_t             load_word,
  output logic                   result_valid,
  input  logic                   result_stall,
  output result_word_t           result_word,
  input  logic                   psel,
  input  logic                   penable,
  input  logic                   pwrite,
  input  logic [PADDR_WIDTH-1:0] paddr,
  input  logic [PDATA_WIDTH-1:0] pwdata,
  output logic [PDATA_WIDTH-1:0] prdata,
  output logic                   pready
);

  localparam int unsigned DEPTH       = MAX_DIM * MAX_DIM;
  localparam int unsigned ADDR_WIDTH  = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int unsigned COUNT_WIDTH = $clog2(DEPTH + 1);
  localparam int unsigned IDX_WIDTH   = (MAX_DIM > 1) ? $clog2(MAX_DIM) : 1;
  localparam int unsigned NEED_WIDTH  = 2 * DIM_WIDTH;
  localparam logic [DIM_WIDTH-1:0] DIM_LIMIT = DIM_WIDTH'(MAX_DIM);

  // Configuration registers
  logic [DIM_WIDTH-1:0]  row_count;
  logic [DIM_WIDTH-1:0]  inner_count;
  logic [DIM_WIDTH-1:0]  col_count;
  logic [MODE_WIDTH-1:0] op_mode;
  logic                  cfg_write;

  // Load side
  logic [DIM_WIDTH-1:0]   r, k, c;
  logic                   is_mul;
  term_kind_t             kind;
  logic [NEED_WIDTH-1:0]  need_a, need_b;
  logic [COUNT_WIDTH-1:0] cnt_a, cnt_b;
  logic                   a_room, b_room;
  logic                   load_accept;
  logic                   we_a, we_b;
  logic                   start;

  // Sequencer
  seq_state_t             state, state_next;
  logic [IDX_WIDTH-1:0]   i, j, t;
  logic [IDX_WIDTH-1:0]   i_next, j_next, t_next;
  logic                   t_last, i_last, elem_last;
  logic                   emit_fire;
  alu_ctrl_t              ctrl;
  logic [NEED_WIDTH-1:0]  a_rd_full, b_rd_full;
  logic [ADDR_WIDTH-1:0]  a_rd, b_rd;
  logic [VALUE_WIDTH-1:0] a_data, b_data;
  logic signed [VALUE_WIDTH-1:0] sat_value;
  logic                   clipped;

  // Configuration port: always ready, write on the access cycle
  assign pready    = 1'b1;
  assign cfg_write = psel && penable && pwrite && pready;

  always_ff @(posedge clk) begin
    if (rst) begin
      row_count   <= ROW_COUNT_RESET;
      inner_count <= INNER_COUNT_RESET;
      col_count   <= COL_COUNT_RESET;
      op_mode     <= OP_MODE_RESET;
    end else if (cfg_write) begin
      unique case (paddr[PADDR_WIDTH-1:2])
        REG_ROW_COUNT:   row_count   <= pwdata[DIM_WIDTH-1:0];
        REG_INNER_COUNT: inner_count <= pwdata[DIM_WIDTH-1:0];
        REG_COL_COUNT:   col_count   <= pwdata[DIM_WIDTH-1:0];
        REG_OP_MODE:     op_mode     <= pwdata[MODE_WIDTH-1:0];
      endcase
    end
  end

  // Read back the addressed register
  always_comb begin
    unique case (paddr[PADDR_WIDTH-1:2])
      REG_ROW_COUNT:   prdata = PDATA_WIDTH'(row_count);
      REG_INNER_COUNT: prdata = PDATA_WIDTH'(inner_count);
      REG_COL_COUNT:   prdata = PDATA_WIDTH'(col_count);
      REG_OP_MODE:     prdata = PDATA_WIDTH'(op_mode);
    endcase
  end

  // Effective dimensions and element counts needed
  assign r      = dim_clamp(row_count, DIM_LIMIT);
  assign k      = dim_clamp(inner_count, DIM_LIMIT);
  assign c      = dim_clamp(col_count, DIM_LIMIT);
  assign is_mul = (op_mode == MODE_MULTIPLY) || (op_mode == MODE_MULTIPLY_ALT);
  assign kind   = is_mul ? TERM_PRODUCT : ((op_mode == MODE_ADD) ? TERM_SUM : TERM_DIFF);
  assign need_a = is_mul ? NEED_WIDTH'(r) * NEED_WIDTH'(k) : NEED_WIDTH'(r) * NEED_WIDTH'(c);
  assign need_b = is_mul ? NEED_WIDTH'(k) * NEED_WIDTH'(c) : NEED_WIDTH'(r) * NEED_WIDTH'(c);

  // Store load words; the word that completes B starts the result
  assign load_stall  = (state != ST_IDLE);
  assign load_accept = load_valid && !load_stall;
  assign a_room      = NEED_WIDTH'(cnt_a) < need_a;
  assign b_room      = NEED_WIDTH'(cnt_b) < need_b;
  assign we_a        = load_accept && !load_word.operand_select && a_room;
  assign we_b        = load_accept && load_word.operand_select && b_room;
  assign start       = load_accept && load_word.operand_select &&
                       (!b_room || (NEED_WIDTH'(cnt_b) + NEED_WIDTH'(1) == need_b));

  always_ff @(posedge clk) begin
    if (rst) begin
      cnt_a <= '0;
      cnt_b <= '0;
    end else if (start) begin
      cnt_a <= '0;
      cnt_b <= '0;
    end else begin
      if (we_a) begin
        cnt_a <= cnt_a + COUNT_WIDTH'(1);
      end
      if (we_b) begin
        cnt_b <= cnt_b + COUNT_WIDTH'(1);
      end
    end
  end

  // Store read addresses: A[i][t] at t*R+i, B[t][j] at j*K+t; element-wise at j*R+i
  assign a_rd_full = is_mul ? NEED_WIDTH'(t) * NEED_WIDTH'(r) + NEED_WIDTH'(i)
                            : NEED_WIDTH'(j) * NEED_WIDTH'(r) + NEED_WIDTH'(i);
  assign b_rd_full = is_mul ? NEED_WIDTH'(j) * NEED_WIDTH'(k) + NEED_WIDTH'(t)
                            : NEED_WIDTH'(j) * NEED_WIDTH'(r) + NEED_WIDTH'(i);
  assign a_rd      = a_rd_full[ADDR_WIDTH-1:0];
  assign b_rd      = b_rd_full[ADDR_WIDTH-1:0];

  smma_ram #(
    .WIDTH (VALUE_WIDTH),
    .DEPTH (DEPTH)
  ) u_store_a (
    .clk     (clk),
    .wr_en   (we_a),
    .wr_addr (cnt_a[ADDR_WIDTH-1:0]),
    .wr_data (load_word.element_value),
    .rd_addr (a_rd),
    .rd_data (a_data)
  );

  smma_ram #(
    .WIDTH (VALUE_WIDTH),
    .DEPTH (DEPTH)
  ) u_store_b (
    .clk     (clk),
    .wr_en   (we_b),
    .wr_addr (cnt_b[ADDR_WIDTH-1:0]),
    .wr_data (load_word.element_value),
    .rd_addr (b_rd),
    .rd_data (b_data)
  );

  smma_alu u_alu (
    .clk       (clk),
    .ctrl      (ctrl),
    .a         (a_data),
    .b         (b_data),
    .sat_value (sat_value),
    .clipped   (clipped)
  );

  // Position within the result
  assign t_last    = DIM_WIDTH'(t) == k - DIM_WIDTH'(1);
  assign i_last    = DIM_WIDTH'(i) == r - DIM_WIDTH'(1);
  assign elem_last = i_last && (DIM_WIDTH'(j) == c - DIM_WIDTH'(1));

  // Sequencer state register
  always_ff @(posedge clk) begin
    if (rst) begin
      state <= ST_IDLE;
    end else begin
      state <= state_next;
    end
  end

  // Next state, unit controls and index steps
  always_comb begin
    state_next = state;
    ctrl       = '0;
    ctrl.kind  = kind;
    ctrl.first = (t == '0);
    emit_fire  = 1'b0;
    t_next     = t;
    i_next     = i;
    j_next     = j;
    unique case (state)
      ST_IDLE: begin
        if (start) begin
          state_next = ST_READ;
          t_next     = '0;
          i_next     = '0;
          j_next     = '0;
        end
      end
      ST_READ: begin
        state_next = ST_MULT;
      end
      ST_MULT: begin
        ctrl.capture = 1'b1;
        state_next   = ST_ACCUM;
      end
      ST_ACCUM: begin
        ctrl.accumulate = 1'b1;
        if (is_mul && !t_last) begin
          t_next     = t + IDX_WIDTH'(1);
          state_next = ST_READ;
        end else begin
          state_next = ST_EMIT;
        end
      end
      ST_EMIT: begin
        if (!result_valid || !result_stall) begin
          emit_fire = 1'b1;
          t_next    = '0;
          if (elem_last) begin
            state_next = ST_IDLE;
          end else begin
            state_next = ST_READ;
            if (i_last) begin
              i_next = '0;
              j_next = j + IDX_WIDTH'(1);
            end else begin
              i_next = i + IDX_WIDTH'(1);
            end
          end
        end
      end
      default: begin
        state_next = ST_IDLE;
      end
    endcase
  end

  // Advance the indices
  always_ff @(posedge clk) begin
    if (rst) begin
      t <= '0;
      i <= '0;
      j <= '0;
    end else begin
      t <= t_next;
      i <= i_next;
      j <= j_next;
    end
  end

  // Output register: load a new word when empty or being taken, else hold
  always_ff @(posedge clk) begin
    if (rst) begin
      result_valid <= 1'b0;
    end else if (emit_fire) begin
      result_valid <= 1'b1;
    end else if (!result_stall) begin
      result_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (emit_fire) begin
      result_word.result_value <= sat_value;
      result_word.result_row   <= INDEX_WIDTH'(i);
      result_word.result_col   <= INDEX_WIDTH'(j);
      result_word.saturated    <= clipped;
      result_word.last_result  <= elem_last;
    end
  end

  // Checks
  `ASSERT_NEXT(a_last_ends, clk, rst, emit_fire && elem_last, state == ST_IDLE && result_word.last_result, "last result word did not return the sequencer to idle")
  `ASSERT_NEXT(a_start_runs, clk, rst, start, state == ST_READ && cnt_a == '0 && cnt_b == '0, "completing B word did not start the result with cleared counts")
  `ASSERT_NOW(a_busy_no_load, clk, rst, state != ST_IDLE, !we_a && !we_b && cnt_a == '0 && cnt_b == '0, "store written or count held while producing a result")

endmodule

`default_nettype wire

FILE: tb/tb_small_matrix_multiply_add.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_small_matrix_multiply_add
// Drives matrix elements into the unit and checks every streamed result
// element against typed-in values or a model of the multiply/add/subtract datapath.
// Both stores are first filled by a full-size multiply at reset settings.
// A table of directed loads follows: saturation, floor rounding, modes,
// surplus elements, clamped sizes and a size change mid-load. Random
// phases then change the sizes and the mode and load matrices in order,
// with surplus or interleaved elements in some phases.
// ----------------------------------------------------------------------------

module tb_small_matrix_multiply_add;
  import smma_pkg::*;

  localparam logic    OPERAND_A  = 1'b0;
  localparam logic    OPERAND_B  = 1'b1;
  localparam longint  VALUE_MAX  = 64'sh0000_0000_7FFF_FFFF;
  localparam longint  VALUE_MIN  = -VALUE_MAX - 1;
  localparam int      RANDOM_ITEMS = 80;

  // Bench clock and block inputs, all known from time zero
  logic                   clk          = 1'b0;
  logic                   rst          = 1'b1;
  logic                   load_valid   = 1'b0;
  load_word_t             load_word    = '0;
  logic                   result_stall = 1'b0;
  logic                   psel         = 1'b0;
  logic                   penable      = 1'b0;
  logic                   pwrite       = 1'b0;
  logic [PADDR_WIDTH-1:0] paddr        = '0;
  logic [PDATA_WIDTH-1:0] pwdata       = '0;

  logic                   load_stall;
  logic                   result_valid;
  result_word_t           result_word;
  logic [PDATA_WIDTH-1:0] prdata;
  logic                   pready;

  // Quiet stretch: no idling on either side while set
  bit calm = 1'b0;
  int errors = 0;

  // Behavioural copy of the unit's registers and stores
  logic [DIM_WIDTH-1:0]    row_reg   = ROW_COUNT_RESET;
  logic [DIM_WIDTH-1:0]    inner_reg = INNER_COUNT_RESET;
  logic [DIM_WIDTH-1:0]    col_reg   = COL_COUNT_RESET;
  logic [MODE_WIDTH-1:0]   mode_reg  = OP_MODE_RESET;
  logic signed [31:0]      a_mem [64];
  logic signed [31:0]      b_mem [64];
  int                      a_fill = 0;
  int                      b_fill = 0;
  result_word_t            due_results [$];

  // Directed plan: register writes and element loads
  typedef struct {
    bit           is_reg;
    logic [1:0]   reg_idx;
    logic [31:0]  data;
    logic         to_b;
    bit           typed;
    result_word_t want;
  } plan_row_t;

  plan_row_t plan [$];

  always #10 clk = ~clk;

  small_matrix_multiply_add u_dut (
    .clk          (clk),
    .rst          (rst),
    .load_valid   (load_valid),
    .load_stall   (load_stall),
    .load_word    (load_word),
    .result_valid (result_valid),
    .result_stall (result_stall),
    .result_word  (result_word),
    .psel         (psel),
    .penable      (penable),
    .pwrite       (pwrite),
    .paddr        (paddr),
    .pwdata       (pwdata),
    .prdata       (prdata),
    .pready       (pready)
  );

  // Zero counts as one, anything past the limit as the limit
  function automatic int effective_dim(input logic [DIM_WIDTH-1:0] v);
    if (v == 0) return 1;
    if (v > MAX_DIM_DEFAULT) return MAX_DIM_DEFAULT;
    return int'(v);
  endfunction

  // Store one element; on the last B word of a set, work out the whole result matrix
  function automatic void absorb_element(input load_word_t w, input bit record);
    int r, k, c, need_a, need_b;
    bit mul;
    longint acc;
    result_word_t res;
    r = effective_dim(row_reg);
    k = effective_dim(inner_reg);
    c = effective_dim(col_reg);
    mul = (mode_reg == MODE_MULTIPLY) || (mode_reg == MODE_MULTIPLY_ALT);
    need_a = mul ? r * k : r * c;
    need_b = mul ? k * c : r * c;
    if (w.operand_select == OPERAND_A) begin
      if (a_fill < need_a) begin
        a_mem[a_fill % 64] = w.element_value;
        a_fill++;
      end
      return;
    end
    if (b_fill < need_b) begin
      b_mem[b_fill % 64] = w.element_value;
      b_fill++;
    end
    if (b_fill < need_b) return;
    for (int j = 0; j < c; j++) begin
      for (int i = 0; i < r; i++) begin
        acc = 0;
        if (mul) begin
          // floor each product back to Q16.16, sum exactly
          for (int t = 0; t < k; t++) begin
            acc += (longint'(a_mem[(t * r + i) % 64]) *
                    longint'(b_mem[(j * k + t) % 64])) >>> FRAC_BITS;
          end
        end else if (mode_reg == MODE_ADD) begin
          acc = longint'(a_mem[(j * r + i) % 64]) + longint'(b_mem[(j * r + i) % 64]);
        end else begin
          acc = longint'(a_mem[(j * r + i) % 64]) - longint'(b_mem[(j * r + i) % 64]);
        end
        res.saturated = 1'b0;
        if (acc > VALUE_MAX) begin
          acc = VALUE_MAX;
          res.saturated = 1'b1;
        end else if (acc < VALUE_MIN) begin
          acc = VALUE_MIN;
          res.saturated = 1'b1;
        end
        res.result_value = 32'(acc);
        res.result_row   = 3'(i);
        res.result_col   = 3'(j);
        res.last_result  = (i == r - 1) && (j == c - 1);
        if (record) due_results.push_back(res);
      end
    end
    a_fill = 0;
    b_fill = 0;
  endfunction

  function automatic void check_field(input string what, input logic [31:0] want,
                                      input logic [31:0] got);
    if (got !== want) begin
      $display("%0t: %s mismatch, expected %h, actual %h", $time, what, want, got);
      errors++;
    end
  endfunction

  function automatic logic [31:0] rand_element();
    int unsigned roll;
    roll = $urandom_range(99);
    if (roll < 25) return $urandom();
    // values within +/-16.0
    if (roll < 70) return 32'($urandom_range(32'h001F_FFFF)) - 32'h0010_0000;
    if (roll < 85) begin
      case ($urandom_range(3))
        0:       return 32'h7FFF_FFFF;
        1:       return 32'h8000_0000;
        2:       return 32'h0001_0000;
        default: return 32'hFFFF_0000;
      endcase
    end
    case ($urandom_range(3))
      0:       return 32'h0000_0000;
      1:       return 32'h0000_0001;
      2:       return 32'hFFFF_FFFF;
      default: return 32'h0000_8000;
    endcase
  endfunction

  // Mostly small sizes; now and then large, zero or past the limit
  function automatic logic [DIM_WIDTH-1:0] pick_dim();
    int unsigned roll;
    roll = $urandom_range(99);
    if (roll < 5) return 4'd0;
    if (roll < 10) return 4'($urandom_range(15, 9));
    if (roll < 22) return 4'($urandom_range(8, 4));
    return 4'($urandom_range(3, 1));
  endfunction

  function automatic plan_row_t reg_row(input logic [1:0] idx, input logic [31:0] val);
    plan_row_t row;
    row.is_reg  = 1'b1;
    row.reg_idx = idx;
    row.data    = val;
    row.to_b    = 1'b0;
    row.typed   = 1'b0;
    row.want    = '0;
    return row;
  endfunction

  function automatic plan_row_t elem_row(input logic sel, input logic [31:0] val);
    plan_row_t row;
    row.is_reg  = 1'b0;
    row.reg_idx = REG_ROW_COUNT;
    row.data    = val;
    row.to_b    = sel;
    row.typed   = 1'b0;
    row.want    = '0;
    return row;
  endfunction

  // B word closing a 1x1 set, with its single result typed in
  function automatic plan_row_t elem_check(input logic [31:0] val, input logic [31:0] value,
                                           input logic sat);
    plan_row_t row;
    row = elem_row(OPERAND_B, val);
    row.typed                  = 1'b1;
    row.want.result_value      = value;
    row.want.result_row        = '0;
    row.want.result_col        = '0;
    row.want.saturated         = sat;
    row.want.last_result       = 1'b1;
    return row;
  endfunction

  // Offer one word, hold it until taken, then note what it causes
  task automatic send_element(input logic sel, input logic [31:0] val, input bit typed,
                              input result_word_t want);
    load_word_t w;
    w.operand_select = sel;
    w.element_value  = val;
    while (!calm && $urandom_range(99) < 9) begin
      load_valid <= 1'b0;
      @(posedge clk);
    end
    load_valid <= 1'b1;
    load_word  <= w;
    do @(posedge clk); while (load_stall);
    absorb_element(w, !typed);
    if (typed) due_results.push_back(want);
  endtask

  // Hold the load side until every result is out and the unit has gone quiet
  task automatic settle();
    load_valid <= 1'b0;
    while (due_results.size() != 0) @(posedge clk);
    repeat (8) @(posedge clk);
  endtask

  // Setup phase, access phase, then idle on the bus
  task automatic write_reg(input logic [1:0] idx, input logic [31:0] val);
    psel    <= 1'b1;
    penable <= 1'b0;
    pwrite  <= 1'b1;
    paddr   <= {idx, 2'b00};
    pwdata  <= val;
    @(posedge clk);
    penable <= 1'b1;
    do @(posedge clk); while (!pready);
    psel    <= 1'b0;
    penable <= 1'b0;
    pwrite  <= 1'b0;
    @(posedge clk);
    case (idx)
      REG_ROW_COUNT:   row_reg   = val[DIM_WIDTH-1:0];
      REG_INNER_COUNT: inner_reg = val[DIM_WIDTH-1:0];
      REG_COL_COUNT:   col_reg   = val[DIM_WIDTH-1:0];
      default:         mode_reg  = val[MODE_WIDTH-1:0];
    endcase
  endtask

  // Random back-pressure on the result side
  always @(posedge clk) begin
    if (rst) begin
      result_stall <= 1'b0;
    end else begin
      result_stall <= !calm && ($urandom_range(99) < 9);
    end
  end

  // Compare each taken result word with the oldest one due
  always @(posedge clk) begin : result_check
    result_word_t want;
    if (!rst && result_valid && !result_stall) begin
      if (due_results.size() == 0) begin
        $display("%0t: result with none due, expected none, actual %h", $time, result_word);
        errors++;
      end else begin
        want = due_results.pop_front();
        check_field("result_value", want.result_value, result_word.result_value);
        check_field("result_row", 32'(want.result_row), 32'(result_word.result_row));
        check_field("result_col", 32'(want.result_col), 32'(result_word.result_col));
        check_field("saturated", 32'(want.saturated), 32'(result_word.saturated));
        check_field("last_result", 32'(want.last_result), 32'(result_word.last_result));
      end
    end
  end

  initial begin : stimulus
    int taken, phase, na, nb, sa, sb;
    bit mul;
    int unsigned shape;
    logic [DIM_WIDTH-1:0]  rv, kv, cv;
    logic [MODE_WIDTH-1:0] mv;
    taken = 0;
    phase = 0;
    for (int n = 0; n < 64; n++) begin
      a_mem[n] = '0;
      b_mem[n] = '0;
    end

    // Directed plan, all 1x1 unless noted
    plan.push_back(reg_row(REG_ROW_COUNT, 1));
    plan.push_back(reg_row(REG_INNER_COUNT, 1));
    plan.push_back(reg_row(REG_COL_COUNT, 1));
    plan.push_back(reg_row(REG_OP_MODE, 32'(MODE_ADD)));
    plan.push_back(elem_row(OPERAND_A, 32'h7FFF_FFFF));
    plan.push_back(elem_check(32'h0000_0001, 32'h7FFF_FFFF, 1'b1));
    plan.push_back(elem_row(OPERAND_A, 32'h8000_0000));
    plan.push_back(elem_check(32'h8000_0000, 32'h8000_0000, 1'b1));
    plan.push_back(reg_row(REG_OP_MODE, 32'(MODE_SUBTRACT)));
    plan.push_back(elem_row(OPERAND_A, 32'h7FFF_FFFF));
    plan.push_back(elem_check(32'hFFFF_FFFF, 32'h7FFF_FFFF, 1'b1));
    plan.push_back(elem_row(OPERAND_A, 32'h0003_0000));
    plan.push_back(elem_check(32'h0005_0000, 32'hFFFE_0000, 1'b0));
    plan.push_back(reg_row(REG_OP_MODE, 32'(MODE_MULTIPLY)));
    // tiny negative product floors to minus one lsb
    plan.push_back(elem_row(OPERAND_A, 32'hFFFF_FFFF));
    plan.push_back(elem_check(32'h0000_0001, 32'hFFFF_FFFF, 1'b0));
    plan.push_back(elem_row(OPERAND_A, 32'h8000_0000));
    plan.push_back(elem_check(32'h8000_0000, 32'h7FFF_FFFF, 1'b1));
    // second A word is surplus and dropped
    plan.push_back(elem_row(OPERAND_A, 32'h0001_0000));
    plan.push_back(elem_row(OPERAND_A, 32'h1234_5678));
    plan.push_back(elem_check(32'h0005_0000, 32'h0005_0000, 1'b0));
    plan.push_back(reg_row(REG_OP_MODE, 32'(MODE_MULTIPLY_ALT)));
    plan.push_back(elem_row(OPERAND_A, 32'h0002_0000));
    plan.push_back(elem_check(32'h0003_0000, 32'h0006_0000, 1'b0));
    // zero sizes behave as one
    plan.push_back(reg_row(REG_ROW_COUNT, 0));
    plan.push_back(reg_row(REG_INNER_COUNT, 0));
    plan.push_back(reg_row(REG_COL_COUNT, 0));
    plan.push_back(elem_row(OPERAND_A, 32'h0000_8000));
    plan.push_back(elem_check(32'h0000_8000, 32'h0000_4000, 1'b0));
    // shrink the set mid-load: the next B word is not stored and fires at once
    plan.push_back(reg_row(REG_OP_MODE, 32'(MODE_ADD)));
    plan.push_back(reg_row(REG_ROW_COUNT, 2));
    plan.push_back(elem_row(OPERAND_A, 32'h0001_0000));
    plan.push_back(elem_row(OPERAND_A, 32'h0002_0000));
    plan.push_back(elem_row(OPERAND_B, 32'h0010_0000));
    plan.push_back(reg_row(REG_ROW_COUNT, 1));
    plan.push_back(elem_row(OPERAND_B, 32'h7777_7777));

    repeat (8) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    // Full 8x8x8 multiply at reset settings writes every store entry, with no idling
    calm = 1'b1;
    for (int n = 0; n < 64; n++) send_element(OPERAND_A, rand_element(), 1'b0, '0);
    for (int n = 0; n < 64; n++) send_element(OPERAND_B, rand_element(), 1'b0, '0);
    settle();
    calm = 1'b0;

    foreach (plan[p]) begin
      if (plan[p].is_reg) begin
        settle();
        write_reg(plan[p].reg_idx, plan[p].data);
      end else begin
        send_element(plan[p].to_b, plan[p].data, plan[p].typed, plan[p].want);
      end
    end

    // Random phases: new sizes and mode, then one matrix pair
    while (taken < RANDOM_ITEMS) begin
      rv = pick_dim();
      kv = pick_dim();
      cv = pick_dim();
      mv = MODE_WIDTH'($urandom_range(3));
      settle();
      calm = (phase >= 6) && (phase < 12);
      write_reg(REG_ROW_COUNT, {28'($urandom()), rv});
      write_reg(REG_INNER_COUNT, {28'($urandom()), kv});
      write_reg(REG_COL_COUNT, {28'($urandom()), cv});
      write_reg(REG_OP_MODE, {30'($urandom()), mv});
      mul = (mv == MODE_MULTIPLY) || (mv == MODE_MULTIPLY_ALT);
      na = mul ? effective_dim(rv) * effective_dim(kv) : effective_dim(rv) * effective_dim(cv);
      nb = mul ? effective_dim(kv) * effective_dim(cv) : effective_dim(rv) * effective_dim(cv);
      shape = $urandom_range(99);
      if (shape < 15) begin
        // interleave A and B words
        sa = 0;
        sb = 0;
        while (sa < na || sb < nb) begin
          if (sb == nb || (sa < na && $urandom_range(1) == 1)) begin
            send_element(OPERAND_A, rand_element(), 1'b0, '0);
            sa++;
          end else begin
            send_element(OPERAND_B, rand_element(), 1'b0, '0);
            sb++;
          end
        end
      end else begin
        for (int n = 0; n < na; n++) send_element(OPERAND_A, rand_element(), 1'b0, '0);
        if (shape < 30) begin
          repeat ($urandom_range(3, 1)) send_element(OPERAND_A, rand_element(), 1'b0, '0);
        end
        for (int n = 0; n < nb; n++) send_element(OPERAND_B, rand_element(), 1'b0, '0);
      end
      taken += na + nb;
      phase++;
    end

    calm = 1'b0;
    settle();
    repeat (20) @(posedge clk);
    if (errors == 0 && due_results.size() == 0) begin
      $display("TEST PASSED");
    end else begin
      $display("TEST FAILED");
    end
    $finish;
  end

  // Guard against a hung handshake
  initial begin
    #100_000_000;
    $display("TEST FAILED");
    $finish;
  end

endmodule
